/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

/* sv/mvm_pkg.sv */
// Shared types and constants for the matrix-vector multiply block.
// No dependencies.
`timescale 1ns / 1ps

package mvm_pkg;

    localparam int MAX_COLS  = 4096;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int COLS_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W     = 16;
    localparam int ROWS_W    = 17;
    localparam int ROW_LIMIT = 65536;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

    // item modes
    localparam logic MODE_VEC_WRITE  = 1'b0;
    localparam logic MODE_MAT_STREAM = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [11:0]              vec_index;
        logic signed [ELEM_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [ACC_W-1:0] dot_product;
        logic                    last_row;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic vec_write;
        logic vec_read;
        logic mul;
        logic acc;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_end;
        logic out_blocked;
    } dp_status_t;

endpackage

/* sv/matrix_vector_multiply.sv */
// Top level of the streaming fixed-point matrix-vector multiply.
// Depends on mvm_pkg, mvm_ctrl, mvm_datapath and assert_macros.svh.
//
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | in_data (mode, vec_index, value)
// out     | output    | out_valid / out_stall | out_data (row_index, dot_product, last_row)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A vector write (mode 0) is stored as it is taken; a matrix element (mode 1) passes through
// the registered vector store read, the product register and the accumulate.
// At a row end the accumulate step waits while the output register holds an untaken
// transaction; otherwise a new item is taken while a result still waits.
// Reset clears the counters, accumulator and output valid; the vector store is not
// cleared and has no clearing pass. cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_vector_multiply (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  mvm_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mvm_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mvm_pkg::dp_cmd_t    cmd;
    mvm_pkg::dp_status_t status;
    logic [3:0]          cmd_bits;

    assign cfg_ready = 1'b1;
    assign cmd_bits  = {cmd.vec_write, cmd.vec_read, cmd.mul, cmd.acc};

    mvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .status   (status),
        .cmd      (cmd),
        .busy     (in_stall)
    );

    mvm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `ASSERT_CLK(a_one_cmd, $onehot0(cmd_bits), "more than one datapath command")
    `ASSERT_CLK(a_rose_after_acc, $rose(out_valid) |-> $past(cmd.acc), "result without accumulate")
    `ASSERT_NEVER(a_no_overwrite, cmd.acc && status.row_end && status.out_blocked, "result lost")
    `ASSERT_CLK(a_stream_busy, (in_valid && !in_stall && in_data.mode) |=> in_stall, "no stall after matrix item")

endmodule

/* sv/mvm_ctrl.sv */
// Sequencer for the matrix-vector multiply: vector writes, and read, multiply, accumulate.
// Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    input  mvm_pkg::dp_status_t status,
    output mvm_pkg::dp_cmd_t    cmd,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = in_valid && !busy;

    always_comb
    begin
        state_next    = state_reg;
        cmd.vec_write = 1'b0;
        cmd.vec_read  = 1'b0;
        cmd.mul       = 1'b0;
        cmd.acc       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == mvm_pkg::MODE_MAT_STREAM)
                    begin
                        cmd.vec_read = 1'b1;
                        state_next   = ST_MUL;
                    end
                    else
                    begin
                        cmd.vec_write = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // hold while a finished row would overwrite an untaken result
                if (!(status.row_end && status.out_blocked))
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/mvm_datapath.sv */
// Datapath: config registers, vector store, multiplier, accumulator,
// column/row counters and output register. Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  mvm_pkg::in_item_t                     in_data,
    input  mvm_pkg::dp_cmd_t                      cmd,
    output mvm_pkg::dp_status_t                   status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output mvm_pkg::out_item_t                    out_data
);

    logic [mvm_pkg::COLS_W-1:0]        num_cols_reg;
    logic [mvm_pkg::ROWS_W-1:0]        num_rows_reg;
    logic [mvm_pkg::COLS_W-1:0]        cols_eff;
    logic [mvm_pkg::ROWS_W-1:0]        rows_eff;

    logic [mvm_pkg::ELEM_W-1:0]        vec_mem [mvm_pkg::MAX_COLS];
    logic signed [mvm_pkg::ELEM_W-1:0] vec_data_reg;
    logic signed [mvm_pkg::ELEM_W-1:0] value_reg;
    logic signed [mvm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mvm_pkg::ACC_W-1:0]  acc_next;
    logic [mvm_pkg::COL_W-1:0]         col_reg;
    logic [mvm_pkg::ROW_W-1:0]         row_reg;
    logic                              last_row;
    logic                              out_valid_reg;
    mvm_pkg::out_item_t                out_reg;

    // clamp the registers to their legal ranges
    always_comb
    begin
        if (num_cols_reg == '0)
            cols_eff = mvm_pkg::COLS_W'(1);
        else if (num_cols_reg > mvm_pkg::COLS_W'(mvm_pkg::MAX_COLS))
            cols_eff = mvm_pkg::COLS_W'(mvm_pkg::MAX_COLS);
        else
            cols_eff = num_cols_reg;

        if (num_rows_reg == '0)
            rows_eff = mvm_pkg::ROWS_W'(1);
        else if (num_rows_reg > mvm_pkg::ROWS_W'(mvm_pkg::ROW_LIMIT))
            rows_eff = mvm_pkg::ROWS_W'(mvm_pkg::ROW_LIMIT);
        else
            rows_eff = num_rows_reg;
    end

    assign status.row_end     = ({1'b0, col_reg} + mvm_pkg::COLS_W'(1)) >= cols_eff;
    assign status.out_blocked = out_valid_reg && out_stall;
    assign last_row           = ({1'b0, row_reg} + mvm_pkg::ROWS_W'(1)) >= rows_eff;
    assign acc_next           = acc_reg + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_reg[31]}},
                                           prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= mvm_pkg::COLS_W'(mvm_pkg::MAX_COLS);
            num_rows_reg <= mvm_pkg::ROWS_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mvm_pkg::REG_NUM_COLS: num_cols_reg <= cfg_data[mvm_pkg::COLS_W-1:0];
                mvm_pkg::REG_NUM_ROWS: num_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // vector store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.vec_write)
            vec_mem[in_data.vec_index] <= in_data.value;
        if (cmd.vec_read)
            vec_data_reg <= vec_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vec_read)
            value_reg <= in_data.value;
        if (cmd.mul)
            prod_reg <= value_reg * vec_data_reg;
        if (cmd.acc && status.row_end)
        begin
            out_reg.row_index   <= row_reg;
            out_reg.dot_product <= acc_next;
            out_reg.last_row    <= last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (status.row_end)
                begin
                    acc_reg <= '0;
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + mvm_pkg::ROW_W'(1);
                end
                else
                begin
                    acc_reg <= acc_next;
                    col_reg <= col_reg + mvm_pkg::COL_W'(1);
                end
            end

            if (cmd.acc && status.row_end)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
